### rtl/core/v3a_pkg.sv
package v3a_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned WORD_BITS_DEF = 32;

    // Fixed internal widths, sized for the widest legal data word
    localparam int unsigned OPW  = 32;  // operand, sign-extended
    localparam int unsigned PRW  = 64;  // one exact product
    localparam int unsigned SUMW = 66;  // exact sum of up to three products
    localparam int unsigned LINW = 33;  // add, subtract, negate
    localparam int unsigned NUMW = 64;  // shifted dividend and quotient
    localparam int unsigned SQW  = 64;  // radicand and root

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_NEG   = 3'd2,
        CMD_DOT   = 3'd3,
        CMD_CROSS = 3'd4,
        CMD_SCALE = 3'd5,
        CMD_DIV   = 3'd6,
        CMD_MAG   = 3'd7
    } t_cmd;

    // Item state carried through the divide and root stages
    typedef struct packed {
        t_cmd                      cmd;
        logic                      dz;
        logic [2:0]                qneg;
        logic [2:0][LINW-1:0]      lin;
        logic [3:0][SUMW-1:0]      psum;
        logic [2:0][NUMW-1:0]      dnum;
        logic [2:0][OPW-1:0]       drem;
        logic [2:0][NUMW-1:0]      quo;
        logic [OPW-1:0]            dvs;
        logic [SQW-1:0]            srem;
        logic [SQW-1:0]            sres;
    } t_mid;

    typedef struct packed {
        logic           ov;
        logic [OPW-1:0] val;
    } t_sat;

    // Take the low d bits and sign-extend them to the operand width
    function automatic logic signed [OPW-1:0] sext(input logic [OPW-1:0] v,
                                                  input int unsigned d);
        logic signed [OPW-1:0] t;
        t = signed'(v << (OPW - d));
        return t >>> (OPW - d);
    endfunction

    // Clamp to the signed d-bit range, flagging any clamp
    function automatic t_sat sat(input logic signed [SUMW-1:0] v,
                                 input int unsigned d);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        t_sat                   r;
        hi = $signed((SUMW'(1) << (d - 1)) - SUMW'(1));
        lo = ~hi;
        if (v > hi) begin
            r.ov  = 1'b1;
            r.val = hi[OPW-1:0];
        end else if (v < lo) begin
            r.ov  = 1'b1;
            r.val = lo[OPW-1:0];
        end else begin
            r.ov  = 1'b0;
            r.val = v[OPW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/v3a_front.sv
module v3a_front #(
    parameter int unsigned DATA_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [2:0]                    i_cmd,
    input  logic [2:0][v3a_pkg::OPW-1:0]  i_a,
    input  logic [2:0][v3a_pkg::OPW-1:0]  i_b,
    input  logic [v3a_pkg::OPW-1:0]       i_s,
    output logic                          o_vld,
    output v3a_pkg::t_mid                 o_mid
);

    // Stage A: operands
    logic                               r_a_vld;
    v3a_pkg::t_cmd                      r_a_cmd;
    logic signed [v3a_pkg::OPW-1:0]     r_a_a [3];
    logic signed [v3a_pkg::OPW-1:0]     r_a_b [3];
    logic signed [v3a_pkg::OPW-1:0]     r_a_s;

    // Stage B: products and linear results
    logic                               r_b_vld;
    v3a_pkg::t_cmd                      r_b_cmd;
    logic signed [v3a_pkg::PRW-1:0]     r_b_m [6];
    logic [2:0][v3a_pkg::LINW-1:0]      r_b_lin;
    logic [2:0][v3a_pkg::NUMW-1:0]      r_b_dnum;
    logic [v3a_pkg::OPW-1:0]            r_b_dvs;
    logic [2:0]                         r_b_qneg;
    logic                               r_b_dz;

    // Stage C: sums
    logic                               r_c_vld;
    v3a_pkg::t_mid                      r_c;

    logic signed [v3a_pkg::OPW-1:0]     n_ma [6];
    logic signed [v3a_pkg::OPW-1:0]     n_mb [6];
    logic signed [v3a_pkg::PRW-1:0]     n_m  [6];
    logic signed [v3a_pkg::LINW-1:0]    n_lin [3];
    logic [2:0][v3a_pkg::NUMW-1:0]      n_dnum;
    logic [v3a_pkg::OPW-1:0]            n_dvs;
    logic [2:0]                         n_qneg;
    logic                               n_dz;
    v3a_pkg::t_mid                      n_c;

    always_comb begin
        logic signed [v3a_pkg::LINW-1:0] ae;
        logic signed [v3a_pkg::LINW-1:0] be;
        logic signed [v3a_pkg::LINW-1:0] se;
        logic [v3a_pkg::LINW-1:0]        mag;
        for (int k = 0; k < 6; k++) begin
            n_ma[k] = '0;
            n_mb[k] = '0;
        end
        case (r_a_cmd)
            v3a_pkg::CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    n_ma[i] = r_a_a[i];
                    n_mb[i] = r_a_b[i];
                end
            end
            v3a_pkg::CMD_CROSS: begin
                n_ma[0] = r_a_a[1]; n_mb[0] = r_a_b[2];
                n_ma[1] = r_a_a[2]; n_mb[1] = r_a_b[1];
                n_ma[2] = r_a_a[2]; n_mb[2] = r_a_b[0];
                n_ma[3] = r_a_a[0]; n_mb[3] = r_a_b[2];
                n_ma[4] = r_a_a[0]; n_mb[4] = r_a_b[1];
                n_ma[5] = r_a_a[1]; n_mb[5] = r_a_b[0];
            end
            v3a_pkg::CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_ma[i] = r_a_a[i];
                    n_mb[i] = r_a_s;
                end
            end
            v3a_pkg::CMD_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    n_ma[i] = r_a_a[i];
                    n_mb[i] = r_a_a[i];
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            n_m[k] = n_ma[k] * n_mb[k];
        end

        for (int i = 0; i < 3; i++) begin
            ae = $signed({r_a_a[i][v3a_pkg::OPW-1], r_a_a[i]});
            be = $signed({r_a_b[i][v3a_pkg::OPW-1], r_a_b[i]});
            case (r_a_cmd)
                v3a_pkg::CMD_ADD: n_lin[i] = ae + be;
                v3a_pkg::CMD_SUB: n_lin[i] = ae - be;
                v3a_pkg::CMD_NEG: n_lin[i] = -ae;
                default:          n_lin[i] = '0;
            endcase
            mag         = (ae < 0) ? unsigned'(-ae) : unsigned'(ae);
            n_dnum[i]   = {{(v3a_pkg::NUMW-v3a_pkg::LINW){1'b0}}, mag} << FRAC_BITS;
            n_qneg[i]   = r_a_a[i][v3a_pkg::OPW-1] ^ r_a_s[v3a_pkg::OPW-1];
        end
        se    = $signed({r_a_s[v3a_pkg::OPW-1], r_a_s});
        mag   = (se < 0) ? unsigned'(-se) : unsigned'(se);
        n_dvs = mag[v3a_pkg::OPW-1:0];
        n_dz  = (r_a_cmd == v3a_pkg::CMD_DIV) && (r_a_s == '0);
    end

    always_comb begin
        logic signed [v3a_pkg::SUMW-1:0] e [6];
        logic signed [v3a_pkg::SUMW-1:0] tri3;
        for (int k = 0; k < 6; k++) begin
            e[k] = $signed({{(v3a_pkg::SUMW-v3a_pkg::PRW){r_b_m[k][v3a_pkg::PRW-1]}},
                            r_b_m[k]});
        end
        tri3     = e[0] + e[1] + e[2];
        n_c      = '0;
        n_c.cmd  = r_b_cmd;
        n_c.dz   = r_b_dz;
        n_c.qneg = r_b_qneg;
        n_c.lin  = r_b_lin;
        n_c.dnum = r_b_dnum;
        n_c.dvs  = r_b_dvs;
        case (r_b_cmd)
            v3a_pkg::CMD_DOT: begin
                n_c.psum[3] = tri3;
            end
            v3a_pkg::CMD_CROSS: begin
                n_c.psum[0] = e[0] - e[1];
                n_c.psum[1] = e[2] - e[3];
                n_c.psum[2] = e[4] - e[5];
            end
            v3a_pkg::CMD_SCALE: begin
                n_c.psum[0] = e[0];
                n_c.psum[1] = e[1];
                n_c.psum[2] = e[2];
            end
            v3a_pkg::CMD_MAG: begin
                n_c.srem = tri3[v3a_pkg::SQW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cmd <= v3a_pkg::t_cmd'(i_cmd);
            for (int i = 0; i < 3; i++) begin
                r_a_a[i] <= v3a_pkg::sext(i_a[i], DATA_BITS);
                r_a_b[i] <= v3a_pkg::sext(i_b[i], DATA_BITS);
            end
            r_a_s    <= v3a_pkg::sext(i_s, DATA_BITS);
            r_b_cmd  <= r_a_cmd;
            for (int k = 0; k < 6; k++) begin
                r_b_m[k] <= n_m[k];
            end
            for (int i = 0; i < 3; i++) begin
                r_b_lin[i] <= n_lin[i];
            end
            r_b_dnum <= n_dnum;
            r_b_dvs  <= n_dvs;
            r_b_qneg <= n_qneg;
            r_b_dz   <= n_dz;
            r_c      <= n_c;
        end
    end

    assign o_vld = r_c_vld;
    assign o_mid = r_c;

endmodule

### rtl/core/v3a_iter.sv
module v3a_iter #(
    parameter int unsigned DATA_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
    parameter int unsigned STEP      = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  v3a_pkg::t_mid i_mid,
    output logic          o_vld,
    output v3a_pkg::t_mid o_mid
);

    localparam int unsigned DIV_BITS = DATA_BITS + FRAC_BITS;
    localparam int unsigned NUM_IDX  = DIV_BITS - 1 - STEP;
    localparam bit          SQ_ON    = (STEP < DATA_BITS);
    localparam int unsigned SQ_SH    = SQ_ON ? 2 * (DATA_BITS - 1 - STEP) : 0;

    logic          r_vld;
    v3a_pkg::t_mid r_mid;
    v3a_pkg::t_mid n_mid;

    always_comb begin
        logic [v3a_pkg::OPW:0]   trial;
        logic [v3a_pkg::OPW:0]   diff;
        logic [v3a_pkg::SQW-1:0] bitv;
        logic [v3a_pkg::SQW-1:0] tsum;
        n_mid = i_mid;
        // one restoring divide step per lane, next dividend bit down
        for (int i = 0; i < 3; i++) begin
            trial = {i_mid.drem[i], i_mid.dnum[i][NUM_IDX]};
            diff  = trial - {1'b0, i_mid.dvs};
            if (trial >= {1'b0, i_mid.dvs}) begin
                n_mid.drem[i] = diff[v3a_pkg::OPW-1:0];
                n_mid.quo[i]  = {i_mid.quo[i][v3a_pkg::NUMW-2:0], 1'b1};
            end else begin
                n_mid.drem[i] = trial[v3a_pkg::OPW-1:0];
                n_mid.quo[i]  = {i_mid.quo[i][v3a_pkg::NUMW-2:0], 1'b0};
            end
        end
        // one digit-pair root step
        bitv = v3a_pkg::SQW'(1) << SQ_SH;
        tsum = i_mid.sres + bitv;
        if (SQ_ON) begin
            if (i_mid.srem >= tsum) begin
                n_mid.srem = i_mid.srem - tsum;
                n_mid.sres = (i_mid.sres >> 1) + bitv;
            end else begin
                n_mid.sres = i_mid.sres >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_vld = r_vld;
    assign o_mid = r_mid;

endmodule

### rtl/core/v3a_back.sv
module v3a_back #(
    parameter int unsigned DATA_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  v3a_pkg::t_mid           i_mid,
    output logic                    o_vld,
    output logic [v3a_pkg::OPW-1:0] o_r_x,
    output logic [v3a_pkg::OPW-1:0] o_r_y,
    output logic [v3a_pkg::OPW-1:0] o_r_z,
    output logic [v3a_pkg::OPW-1:0] o_r_scalar,
    output logic                    o_div_zero,
    output logic                    o_overflow
);

    logic                          r_vld;
    logic [2:0][v3a_pkg::OPW-1:0]  r_vec;
    logic [v3a_pkg::OPW-1:0]       r_scl;
    logic                          r_dz;
    logic                          r_ov;

    v3a_pkg::t_sat                 n_vec [3];
    v3a_pkg::t_sat                 n_scl;

    always_comb begin
        logic signed [v3a_pkg::SUMW-1:0] sh;
        logic signed [v3a_pkg::SUMW-1:0] ln;
        logic signed [v3a_pkg::SUMW-1:0] qs;
        logic signed [v3a_pkg::SUMW-1:0] q;
        n_scl = '0;
        for (int i = 0; i < 3; i++) begin
            sh = $signed(i_mid.psum[i]) >>> FRAC_BITS;
            ln = $signed({{(v3a_pkg::SUMW-v3a_pkg::LINW){i_mid.lin[i][v3a_pkg::LINW-1]}},
                          i_mid.lin[i]});
            q  = $signed({2'b00, i_mid.quo[i]});
            qs = i_mid.qneg[i] ? -q : q;
            case (i_mid.cmd)
                v3a_pkg::CMD_ADD,
                v3a_pkg::CMD_SUB,
                v3a_pkg::CMD_NEG:   n_vec[i] = v3a_pkg::sat(ln, DATA_BITS);
                v3a_pkg::CMD_CROSS,
                v3a_pkg::CMD_SCALE: n_vec[i] = v3a_pkg::sat(sh, DATA_BITS);
                v3a_pkg::CMD_DIV:   n_vec[i] = i_mid.dz ? '0
                                             : v3a_pkg::sat(qs, DATA_BITS);
                default:            n_vec[i] = '0;
            endcase
        end
        case (i_mid.cmd)
            v3a_pkg::CMD_DOT: begin
                sh    = $signed(i_mid.psum[3]) >>> FRAC_BITS;
                n_scl = v3a_pkg::sat(sh, DATA_BITS);
            end
            v3a_pkg::CMD_MAG: begin
                n_scl = v3a_pkg::sat($signed({2'b00, i_mid.sres}), DATA_BITS);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_vec[i] <= n_vec[i].val;
            end
            r_scl <= n_scl.val;
            r_dz  <= i_mid.dz;
            r_ov  <= n_vec[0].ov | n_vec[1].ov | n_vec[2].ov | n_scl.ov;
        end
    end

    assign o_vld      = r_vld;
    assign o_r_x      = r_vec[0];
    assign o_r_y      = r_vec[1];
    assign o_r_z      = r_vec[2];
    assign o_r_scalar = r_scl;
    assign o_div_zero = r_dz;
    assign o_overflow = r_ov;

endmodule

### rtl/core/vector3_alu.sv
// Three-dimensional vector ALU, signed fixed point (FRAC_BITS fraction bits).
// Input channel: i_valid / o_ready carry one beat of command, vector A,
// vector B and a scalar. Commands: add, subtract, negate A, dot, cross,
// scale A, divide A by the scalar, magnitude of A.
// Output channel: o_valid / i_ready carry one beat per input beat, in order:
// result vector, result scalar, divide-by-zero and overflow flags.
// Results are saturated to the data word; overflow marks any clamp.
// Path: a beat passes front stages A, B and C, the divide stages and the
// output register, DATA_BITS being WORD_BITS capped at 32.
// The divider resolves one quotient bit per stage for all three lanes;
// the square root shares the same stages.
// Throughput: one beat per cycle, every command, while the output is not stalled.
// A stall on the output freezes the whole pipeline; o_ready falls only
// while a finished beat sits unclaimed in the output register, so no beat
// is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline; any beats in
// flight are dropped.
module vector3_alu #(
    parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
    parameter int unsigned WORD_BITS = v3a_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_scalar,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_r_x,
    output logic [31:0] o_r_y,
    output logic [31:0] o_r_z,
    output logic [31:0] o_r_scalar,
    output logic        o_div_zero,
    output logic        o_overflow
);

    // data word is the word size, capped at 32 bits
    localparam int unsigned DATA_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    // one stage per quotient bit; the root needs DATA_BITS of them
    localparam int unsigned ITERS     = DATA_BITS + FRAC_BITS;

    logic                 w_en;
    logic [ITERS:0]       w_vld;
    v3a_pkg::t_mid        w_mid [ITERS+1];

    // advance everything unless the output beat is held up
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    v3a_front #(
        .DATA_BITS (DATA_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_cmd   (i_command),
        .i_a     ({i_a_z, i_a_y, i_a_x}),
        .i_b     ({i_b_z, i_b_y, i_b_x}),
        .i_s     (i_scalar),
        .o_vld   (w_vld[0]),
        .o_mid   (w_mid[0])
    );

    // divide and root stages
    for (genvar k = 0; k < ITERS; k++) begin : g_iter
        v3a_iter #(
            .DATA_BITS (DATA_BITS),
            .FRAC_BITS (FRAC_BITS),
            .STEP      (k)
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_mid   (w_mid[k]),
            .o_vld   (w_vld[k+1]),
            .o_mid   (w_mid[k+1])
        );
    end

    // resolve, saturate and hold the output beat
    v3a_back #(
        .DATA_BITS (DATA_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (w_vld[ITERS]),
        .i_mid      (w_mid[ITERS]),
        .o_vld      (o_valid),
        .o_r_x      (o_r_x),
        .o_r_y      (o_r_y),
        .o_r_z      (o_r_z),
        .o_r_scalar (o_r_scalar),
        .o_div_zero (o_div_zero),
        .o_overflow (o_overflow)
    );

    // reset empties the output register
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a held output freezes the valid chain
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld))
        else $error("pipeline moved during stall");

    // divide by zero gives zeros and no overflow
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> !o_overflow && o_r_x == '0 && o_r_y == '0
                                  && o_r_z == '0 && o_r_scalar == '0)
        else $error("divide by zero result not cleared");

    // vector and scalar results never both carry data
    a_vec_scl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_r_x != '0 || o_r_y != '0 || o_r_z != '0)
            |-> o_r_scalar == '0)
        else $error("vector and scalar result both set");

endmodule
